@@ sv/rcba_pkg.sv @@
// Shared constants, codes and item types of the reference-counted block allocator.
package rcba_pkg;

  localparam int unsigned NUM_BLOCKS = 256;
  localparam int unsigned REF_BITS   = 16;
  localparam int unsigned IDX_W      = $clog2(NUM_BLOCKS);
  localparam int unsigned TOP_W      = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned BB_W       = 17;
  localparam int unsigned OFF_W      = 24;
  localparam int unsigned PROD_W     = IDX_W + BB_W;

  localparam logic [BB_W-1:0]     BB_RESET = BB_W'(64);
  localparam logic [REF_BITS-1:0] REF_MAX  = '1;

  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_ADDREF  = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_LOOKUP  = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_RANGE    = 3'd1;
  localparam logic [2:0] STS_EMPTY    = 3'd2;
  localparam logic [2:0] STS_UNUSED   = 3'd3;
  localparam logic [2:0] STS_OVERFLOW = 3'd4;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] target_blk;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  result_block;
    logic [23:0] byte_offset;
    logic [15:0] reference_count;
    logic [8:0]  blocks_in_use;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } stk_wr_t;

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    addr;
    logic [REF_BITS-1:0] data;
  } ref_wr_t;

endpackage

@@ sv/rcba_tables.sv @@
// Free stack and reference count memories with registered reads.
module rcba_tables (
  input  logic                            clk_i,
  input  logic                            rd_en_i,
  input  logic [rcba_pkg::IDX_W-1:0]      stk_raddr_i,
  input  logic [rcba_pkg::IDX_W-1:0]      ref_raddr_i,
  output logic [rcba_pkg::IDX_W-1:0]      stk_rdata_o,
  output logic [rcba_pkg::REF_BITS-1:0]   ref_rdata_o,
  input  rcba_pkg::stk_wr_t               stk_wr_i,
  input  rcba_pkg::ref_wr_t               ref_wr_i
);
  import rcba_pkg::*;

  logic [IDX_W-1:0]    stk_mem [NUM_BLOCKS];
  logic [REF_BITS-1:0] ref_mem [NUM_BLOCKS];

  logic [IDX_W-1:0]    stk_rd_q;
  logic [REF_BITS-1:0] ref_rd_q;

  always_ff @(posedge clk_i) begin
    if (stk_wr_i.en) begin
      stk_mem[stk_wr_i.addr] <= stk_wr_i.data;
    end
    if (ref_wr_i.en) begin
      ref_mem[ref_wr_i.addr] <= ref_wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      stk_rd_q <= stk_mem[stk_raddr_i];
      ref_rd_q <= ref_mem[ref_raddr_i];
    end
  end

  assign stk_rdata_o = stk_rd_q;
  assign ref_rdata_o = ref_rd_q;

endmodule

@@ sv/refcounted_block_allocator.sv @@
// Top level of the reference-counted block allocator.
// Each item is handled in an accept step and an execute step: the accept cycle
// reads the free stack and the reference count memory, the next cycle modifies,
// writes back and loads the result register; a result left waiting holds the
// item in its execute step. The input is ready again only after the previous
// item has written back, so no read ever sees stale data. After reset, and
// after a clear item has loaded its result, the block sweeps both memories one
// entry per cycle with the input not ready, putting every stack entry back to
// its own index and every count to zero. The byte offset is the block number
// times block_bytes, modulo 2^24.
module refcounted_block_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [rcba_pkg::BB_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rcba_pkg::in_item_t         in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rcba_pkg::out_item_t        out_item_o
);
  import rcba_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_CLEAR = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [IDX_W-1:0]    sweep_q, sweep_d;
  logic [BB_W-1:0]     bb_q;
  logic [TOP_W-1:0]    top_q, top_d;
  logic [2:0]          op_q;
  logic [7:0]          id_q;
  logic                out_valid_q;
  out_item_t           out_item_q, out_item_d;

  logic                in_fire;
  logic                exec_fire;
  logic [IDX_W-1:0]    stk_raddr;
  logic [IDX_W-1:0]    stk_rdata;
  logic [REF_BITS-1:0] ref_rdata;
  stk_wr_t             stk_wr;
  ref_wr_t             ref_wr;
  logic                clr_all;

  logic [2:0]          sts;
  logic [IDX_W-1:0]    res_blk;
  logic                with_off;
  logic [REF_BITS-1:0] rcnt;
  logic [REF_BITS-1:0] cnt_dec;
  logic                id_bad;
  logic [PROD_W-1:0]   prod;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign exec_fire   = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  assign stk_raddr = IDX_W'(top_q - TOP_W'(1));

  rcba_tables u_tables (
    .clk_i       (clk_i),
    .rd_en_i     (in_fire),
    .stk_raddr_i (stk_raddr),
    .ref_raddr_i (in_item_i.target_blk[IDX_W-1:0]),
    .stk_rdata_o (stk_rdata),
    .ref_rdata_o (ref_rdata),
    .stk_wr_i    (stk_wr),
    .ref_wr_i    (ref_wr)
  );

  assign id_bad  = TOP_W'(id_q) >= TOP_W'(NUM_BLOCKS);
  assign cnt_dec = ref_rdata - REF_BITS'(1);

  always_comb begin
    sts      = STS_OK;
    res_blk  = '0;
    with_off = 1'b0;
    rcnt     = '0;
    top_d    = top_q;
    clr_all  = 1'b0;
    stk_wr   = '0;
    ref_wr   = '0;
    case (op_q)
      OP_ALLOC: begin
        if (top_q == '0) begin
          sts = STS_EMPTY;
        end else begin
          top_d       = top_q - TOP_W'(1);
          res_blk     = stk_rdata;
          with_off    = 1'b1;
          rcnt        = REF_BITS'(1);
          ref_wr.en   = 1'b1;
          ref_wr.addr = stk_rdata;
          ref_wr.data = REF_BITS'(1);
        end
      end
      OP_CLEAR: begin
        clr_all = 1'b1;
        top_d   = TOP_W'(NUM_BLOCKS);
      end
      OP_ADDREF, OP_RELEASE, OP_LOOKUP: begin
        res_blk = id_q[IDX_W-1:0];
        if (id_bad) begin
          sts = STS_RANGE;
        end else if (ref_rdata == '0) begin
          sts = STS_UNUSED;
        end else if (op_q == OP_ADDREF) begin
          if (ref_rdata == REF_MAX) begin
            sts  = STS_OVERFLOW;
            rcnt = ref_rdata;
          end else begin
            with_off    = 1'b1;
            rcnt        = ref_rdata + REF_BITS'(1);
            ref_wr.en   = 1'b1;
            ref_wr.addr = id_q[IDX_W-1:0];
            ref_wr.data = ref_rdata + REF_BITS'(1);
          end
        end else if (op_q == OP_RELEASE) begin
          with_off    = 1'b1;
          rcnt        = cnt_dec;
          ref_wr.en   = 1'b1;
          ref_wr.addr = id_q[IDX_W-1:0];
          ref_wr.data = cnt_dec;
          // push the block back once its last reference is gone
          if (cnt_dec == '0 && top_q < TOP_W'(NUM_BLOCKS)) begin
            stk_wr.en   = 1'b1;
            stk_wr.addr = top_q[IDX_W-1:0];
            stk_wr.data = id_q[IDX_W-1:0];
            top_d       = top_q + TOP_W'(1);
          end
        end else begin
          with_off = 1'b1;
          rcnt     = ref_rdata;
        end
      end
      default: begin
      end
    endcase
    // commit only when the result register can take the item
    if (!exec_fire) begin
      stk_wr.en = 1'b0;
      ref_wr.en = 1'b0;
      clr_all   = 1'b0;
      top_d     = top_q;
    end
    // restore one entry of each memory per cycle while sweeping
    if (state_q == S_CLEAR) begin
      stk_wr.en   = 1'b1;
      stk_wr.addr = sweep_q;
      stk_wr.data = sweep_q;
      ref_wr.en   = 1'b1;
      ref_wr.addr = sweep_q;
      ref_wr.data = '0;
    end
  end

  assign prod = PROD_W'(res_blk) * PROD_W'(bb_q);

  always_comb begin
    out_item_d.status          = sts;
    out_item_d.result_block    = 8'(res_blk);
    out_item_d.byte_offset     = with_off ? prod[OFF_W-1:0] : '0;
    out_item_d.reference_count = 16'(rcnt);
    out_item_d.blocks_in_use   = 9'(TOP_W'(NUM_BLOCKS) - top_d);
  end

  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          if (clr_all) begin
            state_d = S_CLEAR;
            sweep_d = '0;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_CLEAR: begin
        sweep_d = sweep_q + IDX_W'(1);
        if (sweep_q == IDX_W'(NUM_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      sweep_q     <= '0;
      bb_q        <= BB_RESET;
      top_q       <= TOP_W'(NUM_BLOCKS);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      top_q   <= top_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bb_q <= cfg_data_i;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q <= in_item_i.operation;
      id_q <= in_item_i.target_blk;
    end
    if (exec_fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ tb/sv/tb_refcounted_block_allocator.sv @@
// Self-checking testbench for the reference-counted block allocator.
module tb_refcounted_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import rcba_pkg::*;

  // Operation codes past clear have no meaning and must leave the pool alone.
  localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0] OP_RSVD_LAST  = 3'd7;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned RANDOM_ITEMS = 300;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [BB_W-1:0]   cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_item_t          in_item_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_item_o;

  // Predicted pool state
  logic [IDX_W-1:0]    free_list [NUM_BLOCKS];
  logic [TOP_W-1:0]    free_count;
  logic [REF_BITS-1:0] use_count [NUM_BLOCKS];
  logic [BB_W-1:0]     bytes_per_block;

  out_item_t   answers_due [$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_request = 0;
  bit          idle_on      = 1'b1;

  refcounted_block_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void free_all();
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      free_list[i] = IDX_W'(i);
      use_count[i] = '0;
    end
    free_count = TOP_W'(NUM_BLOCKS);
  endfunction

  function automatic logic [OFF_W-1:0] offset_of(logic [IDX_W-1:0] blk);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(blk) * PROD_W'(bytes_per_block);
    return prod[OFF_W-1:0];
  endfunction

  // Apply one operation to the predicted pool and return its answer.
  function automatic out_item_t apply_block_op(in_item_t item);
    out_item_t           ans;
    logic [IDX_W-1:0]    blk;
    logic [REF_BITS-1:0] cnt;
    ans = '0;
    blk = item.target_blk[IDX_W-1:0];
    cnt = use_count[blk];
    case (item.operation)
      OP_ALLOC: begin
        if (free_count == '0) begin
          ans.status = STS_EMPTY;
        end else begin
          free_count = free_count - 1'b1;
          blk = free_list[free_count[IDX_W-1:0]];
          use_count[blk] = REF_BITS'(1);
          ans.result_block    = blk;
          ans.byte_offset     = offset_of(blk);
          ans.reference_count = 16'd1;
        end
      end
      OP_CLEAR: begin
        free_all();
      end
      OP_ADDREF, OP_RELEASE, OP_LOOKUP: begin
        ans.result_block = item.target_blk;
        if (int'(item.target_blk) >= NUM_BLOCKS) begin
          ans.status = STS_RANGE;
        end else if (cnt == '0) begin
          ans.status = STS_UNUSED;
        end else if (item.operation == OP_ADDREF && cnt == REF_MAX) begin
          ans.status          = STS_OVERFLOW;
          ans.reference_count = cnt;
        end else begin
          if (item.operation == OP_ADDREF) begin
            cnt = cnt + 1'b1;
          end
          if (item.operation == OP_RELEASE) begin
            cnt = cnt - 1'b1;
            // drop the push if the stack is somehow full
            if (cnt == '0 && free_count < NUM_BLOCKS) begin
              free_list[free_count[IDX_W-1:0]] = blk;
              free_count = free_count + 1'b1;
            end
          end
          use_count[blk]      = cnt;
          ans.byte_offset     = offset_of(blk);
          ans.reference_count = cnt;
        end
      end
      default: ;
    endcase
    ans.blocks_in_use = 9'(NUM_BLOCKS - free_count);
    return ans;
  endfunction

  function automatic logic [7:0] pick_live_block();
    int unsigned start;
    int unsigned idx;
    start = $urandom_range(0, NUM_BLOCKS - 1);
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      idx = (start + i) % NUM_BLOCKS;
      if (use_count[idx] != '0) begin
        return 8'(idx);
      end
    end
    return 8'(start);
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [7:0] id);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{operation: op, target_blk: id};
    do @(posedge clk_i); while (!in_ready_o);
    answers_due.push_back(apply_block_op(in_item_i));
  endtask

  task automatic drain_answers();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_block_bytes(input logic [BB_W-1:0] value);
    drain_answers();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    bytes_per_block = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Every operation, freed-block errors and unused codes from the reset pool.
  task automatic test_basic_ops();
    send_item(OP_ALLOC, 8'($urandom_range(0, 255)));
    send_item(OP_ALLOC, 8'($urandom_range(0, 255)));
    send_item(OP_ADDREF, 8'd255);
    send_item(OP_LOOKUP, 8'd255);
    send_item(OP_RELEASE, 8'd255);
    send_item(OP_RELEASE, 8'd255);
    send_item(OP_LOOKUP, 8'd255);
    send_item(OP_ADDREF, 8'd255);
    send_item(OP_RELEASE, 8'd255);
    send_item(OP_ALLOC, 8'($urandom_range(0, 255)));
    send_item(OP_LOOKUP, 8'd0);
    send_item(OP_ADDREF, 8'd0);
    send_item(OP_RELEASE, 8'd0);
    for (int op = OP_RSVD_FIRST; op <= OP_RSVD_LAST; op++) begin
      send_item(3'(op), 8'($urandom_range(0, 255)));
    end
    send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
    send_item(OP_LOOKUP, 8'd254);
    send_item(OP_ALLOC, 8'($urandom_range(0, 255)));
    drain_answers();
  endtask

  // After a clear the first allocations hand out the highest block numbers.
  task automatic test_block_sizes();
    logic [BB_W-1:0] sizes [6];
    sizes = '{17'd0, 17'd1, 17'd65536, 17'h1FFFF, 17'd3, BB_RESET};
    foreach (sizes[i]) begin
      write_block_bytes(sizes[i]);
      send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
      send_item(OP_ALLOC, 8'($urandom_range(0, 255)));
      send_item(OP_ALLOC, 8'($urandom_range(0, 255)));
      send_item(OP_LOOKUP, 8'd255);
      send_item(OP_ADDREF, 8'd254);
      send_item(OP_RELEASE, 8'd254);
    end
    drain_answers();
  endtask

  task automatic test_pool_exhaustion();
    send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
    repeat (NUM_BLOCKS) send_item(OP_ALLOC, 8'($urandom_range(0, 255)));
    repeat (3) send_item(OP_ALLOC, 8'($urandom_range(0, 255)));
    send_item(OP_LOOKUP, 8'd0);
    send_item(OP_RELEASE, 8'd0);
    send_item(OP_RELEASE, 8'd17);
    // freed blocks come back last in, first out
    repeat (3) send_item(OP_ALLOC, 8'($urandom_range(0, 255)));
    send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
    drain_answers();
  endtask

  // Walk one block's count up and back down until the block is free again.
  task automatic test_count_updates();
    send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
    send_item(OP_ALLOC, 8'($urandom_range(0, 255)));
    repeat (12) send_item(OP_ADDREF, 8'd255);
    send_item(OP_LOOKUP, 8'd255);
    repeat (13) send_item(OP_RELEASE, 8'd255);
    send_item(OP_LOOKUP, 8'd255);
    send_item(OP_ADDREF, 8'd255);
    send_item(OP_ALLOC, 8'($urandom_range(0, 255)));
    send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
    drain_answers();
  endtask

  task automatic test_backpressure();
    hold_request = HOLD_CYCLES;
    repeat (24) begin
      if ($urandom_range(0, 1) != 0) begin
        send_item(OP_ALLOC, 8'($urandom_range(0, 255)));
      end else begin
        send_item(OP_LOOKUP, pick_live_block());
      end
    end
    drain_answers();
  endtask

  task automatic test_random_traffic();
    int unsigned alloc_pct [4];
    int unsigned r;
    logic [2:0]  op;
    logic [7:0]  id;
    alloc_pct = '{30, 45, 25, 35};
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 3) begin
        write_block_bytes(BB_W'($urandom_range(0, (1 << BB_W) - 1)));
      end else begin
        write_block_bytes(BB_W'($urandom_range(1, 65536)));
      end
      idle_on = (phase != 2);
      if (phase == 1) begin
        hold_request = HOLD_CYCLES / 3;
      end
      repeat (RANDOM_ITEMS / 4) begin
        r = $urandom_range(0, 99);
        if (r < alloc_pct[phase]) begin
          op = OP_ALLOC;
        end else if (r < 94) begin
          op = 3'($urandom_range(OP_ADDREF, OP_LOOKUP));
        end else if (r < 95) begin
          op = OP_CLEAR;
        end else if (r < 97) begin
          op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        end else begin
          op = 3'($urandom_range(0, 7));
        end
        id = ($urandom_range(0, 3) != 0) ? pick_live_block()
                                         : 8'($urandom_range(0, 255));
        send_item(op, id);
      end
      drain_answers();
    end
    idle_on = 1'b1;
  endtask

  // Result consumer: random stalls per item while idle_on is set, plus one long hold on request.
  initial begin : result_sink
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, 3) : 0;
      if (hold_request != 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  always @(posedge clk_i) begin : check_result
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answers_due.size() == 0) begin
        $error("unexpected result item %p", out_item_o);
        mismatches++;
      end else begin
        want = answers_due.pop_front();
        if (out_item_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item_o.status);
          mismatches++;
        end
        if (out_item_o.result_block !== want.result_block) begin
          $error("result_block: expected %0d, got %0d",
                 want.result_block, out_item_o.result_block);
          mismatches++;
        end
        if (out_item_o.byte_offset !== want.byte_offset) begin
          $error("byte_offset: expected %0d, got %0d",
                 want.byte_offset, out_item_o.byte_offset);
          mismatches++;
        end
        if (out_item_o.reference_count !== want.reference_count) begin
          $error("reference_count: expected %0d, got %0d",
                 want.reference_count, out_item_o.reference_count);
          mismatches++;
        end
        if (out_item_o.blocks_in_use !== want.blocks_in_use) begin
          $error("blocks_in_use: expected %0d, got %0d",
                 want.blocks_in_use, out_item_o.blocks_in_use);
          mismatches++;
        end
      end
    end
  end

  // Count cycles with no handshake on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $error("no progress for %0d cycles", STALL_LIMIT);
      $display("** refcounted_block_allocator: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    free_all();
    bytes_per_block = BB_RESET;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_basic_ops();
    test_block_sizes();
    test_pool_exhaustion();
    test_count_updates();
    test_backpressure();
    test_random_traffic();
    drain_answers();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("** refcounted_block_allocator: PASSED **");
    end else begin
      $display("** refcounted_block_allocator: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/rcba_pkg.sv
sv/rcba_tables.sv
sv/refcounted_block_allocator.sv
tb/sv/tb_refcounted_block_allocator.sv
